// File: rtl/core/ltac_pkg.sv
// ----------------------------------------------------------------------------
// ltac_pkg: shared types and constants of the light tracker axis controller
// Event codes, controller states, motor directions and configuration indexes.
// ----------------------------------------------------------------------------
package ltac_pkg;

	// Brightness sample width and the width used for the dead band compares
	localparam int SAMPLE_BITS = 10;
	localparam int BAND_W      = 10;
	localparam int CMP_W       = ((SAMPLE_BITS > BAND_W) ? SAMPLE_BITS : BAND_W) + 1;

	localparam int TIME_W  = 16;
	localparam int TICKS_W = 24;
	localparam int CFG_W   = 24;
	localparam int IDX_W   = 3;

	// Configuration register indexes
	localparam logic [IDX_W-1:0] REG_DEAD_BAND   = 3'd0;
	localparam logic [IDX_W-1:0] REG_TRACK_TIME  = 3'd1;
	localparam logic [IDX_W-1:0] REG_HOME_TIME   = 3'd2;
	localparam logic [IDX_W-1:0] REG_DARK_TICKS  = 3'd3;
	localparam logic [IDX_W-1:0] REG_WIND_TICKS  = 3'd4;

	// Reset values of the configuration registers
	localparam logic [BAND_W-1:0]  RST_DEAD_BAND  = 10'd10;
	localparam logic [TIME_W-1:0]  RST_TRACK_TIME = 16'd100;
	localparam logic [TIME_W-1:0]  RST_HOME_TIME  = 16'd500;
	localparam logic [TICKS_W-1:0] RST_DARK_TICKS = 24'd60000;
	localparam logic [TICKS_W-1:0] RST_WIND_TICKS = 24'd60000;

	typedef enum logic [1:0] {
		EV_SAMPLE = 2'd0,
		EV_DONE   = 2'd1,
		EV_WIND   = 2'd2,
		EV_TICK   = 2'd3
	} event_t;

	typedef enum logic [1:0] {
		ST_AUTO  = 2'd0,
		ST_DARK  = 2'd1,
		ST_WIND  = 2'd2,
		ST_SLEEP = 2'd3
	} state_t;

	typedef enum logic [1:0] {
		DIR_N = 2'd0,
		DIR_S = 2'd1,
		DIR_E = 2'd2,
		DIR_W = 2'd3
	} dir_t;

	// Decision taken for one event
	typedef struct packed {
		logic              start;
		dir_t              start_dir;
		logic [TIME_W-1:0] start_time;
		logic              stop;
		dir_t              stop_dir;
	} action_t;

endpackage

// File: rtl/core/light_tracker_axis_controller.sv
// ----------------------------------------------------------------------------
// light_tracker_axis_controller: two-axis light tracker controller
// Takes sensor samples, motor-done events, wind alarms and ticks, and issues
// one result per event with move and stop commands, state and limits.
// ----------------------------------------------------------------------------
//
//  channel   direction  handshake               payload
//  in        input      in_valid / in_ready     mode, four levels, is_dark, limit_level
//  out       output     out_valid / out_ready   start/stop commands, state, limits
//  cfg       input      cfg_we (no wait)        cfg_index, cfg_data
//
// The decision is made on the accepted transfer and lands in the output register
// on the same edge, so one event per cycle while the output is not stalled.
// The output register is the only stage; in_ready stays high while it is
// empty or being emptied, so a stalled output holds back only new transfers.
// Reset clears the controller state and loads the register defaults.
module light_tracker_axis_controller (
	input  logic                              clk,
	input  logic                              arst_n,
	// configuration
	input  logic                              cfg_we,
	input  logic [ltac_pkg::IDX_W-1:0]        cfg_index,
	input  logic [ltac_pkg::CFG_W-1:0]        cfg_data,
	// input events
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic [1:0]                        mode,
	input  logic [ltac_pkg::SAMPLE_BITS-1:0]  north_level,
	input  logic [ltac_pkg::SAMPLE_BITS-1:0]  south_level,
	input  logic [ltac_pkg::SAMPLE_BITS-1:0]  east_level,
	input  logic [ltac_pkg::SAMPLE_BITS-1:0]  west_level,
	input  logic                              is_dark,
	input  logic                              limit_level,
	// results
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic                              start_move,
	output logic [1:0]                        move_dir,
	output logic [ltac_pkg::TIME_W-1:0]       move_time,
	output logic                              stop_move,
	output logic [1:0]                        stop_dir,
	output logic [1:0]                        tracker_state,
	output logic [3:0]                        limit_flags
);

	// Configuration registers
	logic [ltac_pkg::BAND_W-1:0]  dead_band_q;
	logic [ltac_pkg::TIME_W-1:0]  track_time_q;
	logic [ltac_pkg::TIME_W-1:0]  home_time_q;
	logic [ltac_pkg::TICKS_W-1:0] dark_ticks_q;
	logic [ltac_pkg::TICKS_W-1:0] wind_ticks_q;

	// Controller state
	ltac_pkg::state_t             state_q, state_d;
	logic [3:0]                   limits_q, limits_d;
	logic                         busy_q, busy_d;
	ltac_pkg::dir_t               dir_q, dir_d;
	logic [ltac_pkg::TICKS_W-1:0] count_q, count_d;
	ltac_pkg::action_t            act;

	// Output register
	logic                         out_valid_q;
	logic                         start_q;
	logic [1:0]                   move_dir_q;
	logic [ltac_pkg::TIME_W-1:0]  move_time_q;
	logic                         stop_q;
	logic [1:0]                   stop_dir_q;
	logic [1:0]                   tstate_q;
	logic [3:0]                   limits_out_q;

	logic                         in_fire;
	ltac_pkg::event_t             ev;
	logic [ltac_pkg::CMP_W-1:0]   n_x, s_x, e_x, w_x, band_x;
	logic                         go_n, go_s, go_e, go_w;

	assign in_ready = !out_valid_q || out_ready;
	assign in_fire  = in_valid && in_ready;
	assign ev       = ltac_pkg::event_t'(mode);

	// Configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dead_band_q  <= ltac_pkg::RST_DEAD_BAND;
			track_time_q <= ltac_pkg::RST_TRACK_TIME;
			home_time_q  <= ltac_pkg::RST_HOME_TIME;
			dark_ticks_q <= ltac_pkg::RST_DARK_TICKS;
			wind_ticks_q <= ltac_pkg::RST_WIND_TICKS;
		end else if (cfg_we) begin
			case (cfg_index)
				ltac_pkg::REG_DEAD_BAND:  dead_band_q  <= cfg_data[ltac_pkg::BAND_W-1:0];
				ltac_pkg::REG_TRACK_TIME: track_time_q <= cfg_data[ltac_pkg::TIME_W-1:0];
				ltac_pkg::REG_HOME_TIME:  home_time_q  <= cfg_data[ltac_pkg::TIME_W-1:0];
				ltac_pkg::REG_DARK_TICKS: dark_ticks_q <= cfg_data[ltac_pkg::TICKS_W-1:0];
				ltac_pkg::REG_WIND_TICKS: wind_ticks_q <= cfg_data[ltac_pkg::TICKS_W-1:0];
				default: ;
			endcase
		end
	end

	// Tracking compares: a difference exceeds the dead band when one level is
	// greater than the other plus the band.
	assign n_x    = ltac_pkg::CMP_W'(north_level);
	assign s_x    = ltac_pkg::CMP_W'(south_level);
	assign e_x    = ltac_pkg::CMP_W'(east_level);
	assign w_x    = ltac_pkg::CMP_W'(west_level);
	assign band_x = ltac_pkg::CMP_W'(dead_band_q);
	assign go_n   = (n_x > s_x + band_x) && !limits_q[ltac_pkg::DIR_N];
	assign go_s   = (s_x > n_x + band_x) && !limits_q[ltac_pkg::DIR_S];
	assign go_e   = (e_x > w_x + band_x) && !limits_q[ltac_pkg::DIR_E];
	assign go_w   = (w_x > e_x + band_x) && !limits_q[ltac_pkg::DIR_W];

	// Next state and the move decision for the event on the input
	always_comb begin
		logic do_home;
		logic [1:0] d;
		state_d = state_q;
		limits_d = limits_q;
		busy_d = busy_q;
		dir_d = dir_q;
		count_d = count_q;
		act = '0;
		do_home = 1'b0;
		d = 2'd0;

		case (ev)
			ltac_pkg::EV_SAMPLE: begin
				if (state_q == ltac_pkg::ST_AUTO && !busy_q) begin
					if (is_dark) begin
						state_d = ltac_pkg::ST_DARK;
						limits_d[ltac_pkg::DIR_N] = 1'b0;
						limits_d[ltac_pkg::DIR_E] = 1'b0;
						do_home = 1'b1;
					end else if (go_n || go_s || go_e || go_w) begin
						act.start = 1'b1;
						act.start_time = track_time_q;
						if (go_n)
							act.start_dir = ltac_pkg::DIR_N;
						else if (go_s)
							act.start_dir = ltac_pkg::DIR_S;
						else if (go_e)
							act.start_dir = ltac_pkg::DIR_E;
						else
							act.start_dir = ltac_pkg::DIR_W;
					end
				end
			end
			ltac_pkg::EV_DONE: begin
				if (busy_q) begin
					// Latch the limit of the moving direction, clear its opposite
					d = dir_q;
					limits_d[d] = limit_level;
					limits_d[d ^ 2'd1] = 1'b0;
					busy_d = 1'b0;
					act.stop = 1'b1;
					act.stop_dir = dir_q;
					do_home = (state_q == ltac_pkg::ST_DARK) || (state_q == ltac_pkg::ST_WIND);
				end
			end
			ltac_pkg::EV_WIND: begin
				if (state_q == ltac_pkg::ST_AUTO) begin
					state_d = ltac_pkg::ST_WIND;
					limits_d[ltac_pkg::DIR_N] = 1'b0;
					do_home = !busy_q;
				end
			end
			ltac_pkg::EV_TICK: begin
				if (state_q == ltac_pkg::ST_SLEEP) begin
					if (count_q != '0)
						count_d = count_q - 1'b1;
					if (count_q <= ltac_pkg::TICKS_W'(1)) begin
						state_d = ltac_pkg::ST_AUTO;
						limits_d = '0;
					end
				end
			end
			default: ;
		endcase

		// Homing step on the updated limits
		if (do_home) begin
			if (!limits_d[ltac_pkg::DIR_N]) begin
				act.start = 1'b1;
				act.start_dir = ltac_pkg::DIR_N;
				act.start_time = home_time_q;
			end else if (state_d == ltac_pkg::ST_DARK && !limits_d[ltac_pkg::DIR_E]) begin
				act.start = 1'b1;
				act.start_dir = ltac_pkg::DIR_E;
				act.start_time = home_time_q;
			end else if (state_d == ltac_pkg::ST_DARK) begin
				limits_d[ltac_pkg::DIR_N] = 1'b0;
				limits_d[ltac_pkg::DIR_E] = 1'b0;
				count_d = dark_ticks_q;
				state_d = ltac_pkg::ST_SLEEP;
			end else begin
				limits_d[ltac_pkg::DIR_N] = 1'b0;
				count_d = wind_ticks_q;
				state_d = ltac_pkg::ST_SLEEP;
			end
		end

		// A started move makes the motor busy
		if (act.start) begin
			busy_d = 1'b1;
			dir_d = act.start_dir;
		end
	end

	// Controller state registers, updated on each accepted transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ltac_pkg::ST_AUTO;
			limits_q <= '0;
			busy_q   <= 1'b0;
			dir_q    <= ltac_pkg::DIR_N;
			count_q  <= '0;
		end else if (in_fire) begin
			state_q  <= state_d;
			limits_q <= limits_d;
			busy_q   <= busy_d;
			dir_q    <= dir_d;
			count_q  <= count_d;
		end
	end

	// Output register valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (in_fire)
			out_valid_q <= 1'b1;
		else if (out_ready)
			out_valid_q <= 1'b0;
	end

	// Output register payload
	always_ff @(posedge clk) begin
		if (in_fire) begin
			start_q      <= act.start;
			move_dir_q   <= act.start_dir;
			move_time_q  <= act.start_time;
			stop_q       <= act.stop;
			stop_dir_q   <= act.stop_dir;
			tstate_q     <= state_d;
			limits_out_q <= limits_d;
		end
	end

	assign out_valid     = out_valid_q;
	assign start_move    = start_q;
	assign move_dir      = move_dir_q;
	assign move_time     = move_time_q;
	assign stop_move     = stop_q;
	assign stop_dir      = stop_dir_q;
	assign tracker_state = tstate_q;
	assign limit_flags   = limits_out_q;

	// Every accepted transfer yields a result in the next cycle.
	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> out_valid)
		else $error("accepted event produced no result");

	// No move fields without a started move.
	a_quiet_move: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !start_move |-> move_dir == 2'd0 && move_time == '0)
		else $error("move fields set without a started move");

	// No stop direction without a stop.
	a_quiet_stop: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !stop_move |-> stop_dir == 2'd0)
		else $error("stop direction set without a stop");

	// Sleeping never starts a move.
	a_sleep_still: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && tracker_state == ltac_pkg::ST_SLEEP |-> !start_move)
		else $error("move started while sleeping");

	// Wind homing only ever drives north.
	a_wind_north: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && start_move && tracker_state == ltac_pkg::ST_WIND
			|-> move_dir == ltac_pkg::DIR_N)
		else $error("wind homing moved away from north");

endmodule

// File: tb/ltac_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ltac_checker: result checker for the light tracker axis controller
// Watches every transfer on the event, result and configuration ports, works
// out the result each accepted event should give, and compares each accepted
// result field by field with the oldest one still awaited.
// ----------------------------------------------------------------------------
module ltac_checker (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [ltac_pkg::IDX_W-1:0]        cfg_index,
	input  logic [ltac_pkg::CFG_W-1:0]        cfg_data,
	input  logic                              in_valid,
	input  logic                              in_ready,
	input  logic [1:0]                        mode,
	input  logic [ltac_pkg::SAMPLE_BITS-1:0]  north_level,
	input  logic [ltac_pkg::SAMPLE_BITS-1:0]  south_level,
	input  logic [ltac_pkg::SAMPLE_BITS-1:0]  east_level,
	input  logic [ltac_pkg::SAMPLE_BITS-1:0]  west_level,
	input  logic                              is_dark,
	input  logic                              limit_level,
	input  logic                              out_valid,
	input  logic                              out_ready,
	input  logic                              start_move,
	input  logic [1:0]                        move_dir,
	input  logic [ltac_pkg::TIME_W-1:0]       move_time,
	input  logic                              stop_move,
	input  logic [1:0]                        stop_dir,
	input  logic [1:0]                        tracker_state,
	input  logic [3:0]                        limit_flags,
	output int                                fail_count,
	output int                                awaited_count
);
	import ltac_pkg::*;

	// One result as the block should present it
	typedef struct packed {
		logic              start;
		dir_t              start_dir;
		logic [TIME_W-1:0] start_time;
		logic              stop;
		dir_t              stop_dir;
		state_t            state;
		logic [3:0]        limits;
	} tracker_result_t;

	// Own copy of the configuration registers
	logic [BAND_W-1:0]  band_q;
	logic [TIME_W-1:0]  track_time_q;
	logic [TIME_W-1:0]  home_time_q;
	logic [TICKS_W-1:0] dark_ticks_q;
	logic [TICKS_W-1:0] wind_ticks_q;

	// Own copy of the controller state
	logic [3:0]         limits_q;
	state_t             state_q;
	logic               busy_q;
	dir_t               heading_q;
	logic [TICKS_W-1:0] sleep_q;

	tracker_result_t awaited_results[$];
	int faults = 0;

	// Prints one line per fault and counts it.
	task automatic report_fault(input string msg);
		$display("%0t ns: %s", $time, msg);
		faults++;
	endtask

	task automatic check_field(input string name, input logic [31:0] got,
		input logic [31:0] want);
		if (got !== want)
			report_fault($sformatf("%s: got 0x%0h, awaited 0x%0h", name, got, want));
	endtask

	// Sets the motor running in one direction and records the start.
	task automatic start_motor(input dir_t dir, input logic [TIME_W-1:0] run_time,
		inout tracker_result_t res);
		busy_q = 1'b1;
		heading_q = dir;
		res.start = 1'b1;
		res.start_dir = dir;
		res.start_time = run_time;
	endtask

	// Next step of a homing run: drive towards the missing limits, or sleep.
	task automatic homing_step(inout tracker_result_t res);
		if (state_q == ST_DARK) begin
			if (!limits_q[DIR_N]) begin
				start_motor(DIR_N, home_time_q, res);
			end else if (!limits_q[DIR_E]) begin
				start_motor(DIR_E, home_time_q, res);
			end else begin
				limits_q[DIR_N] = 1'b0;
				limits_q[DIR_E] = 1'b0;
				sleep_q = dark_ticks_q;
				state_q = ST_SLEEP;
			end
		end else if (state_q == ST_WIND) begin
			if (!limits_q[DIR_N]) begin
				start_motor(DIR_N, home_time_q, res);
			end else begin
				limits_q[DIR_N] = 1'b0;
				sleep_q = wind_ticks_q;
				state_q = ST_SLEEP;
			end
		end
	endtask

	// Works out the result of one event and moves the controller state on.
	task automatic decide_event(input event_t ev,
		input logic [SAMPLE_BITS-1:0] north, south, east, west,
		input logic dark, input logic switch_level, output tracker_result_t res);
		int   vert;
		int   hor;
		int   band;
		dir_t opposite;
		res = '0;
		case (ev)
		EV_SAMPLE: begin
			if (state_q == ST_AUTO && !busy_q) begin
				if (dark) begin
					state_q = ST_DARK;
					limits_q[DIR_N] = 1'b0;
					limits_q[DIR_E] = 1'b0;
					homing_step(res);
				end else begin
					vert = int'(north) - int'(south);
					hor  = int'(east) - int'(west);
					band = int'(band_q);
					// Vertical axis has priority; a latched limit blocks its direction
					if (vert > band && !limits_q[DIR_N])
						start_motor(DIR_N, track_time_q, res);
					else if (vert < -band && !limits_q[DIR_S])
						start_motor(DIR_S, track_time_q, res);
					else if (hor > band && !limits_q[DIR_E])
						start_motor(DIR_E, track_time_q, res);
					else if (hor < -band && !limits_q[DIR_W])
						start_motor(DIR_W, track_time_q, res);
				end
			end
		end
		EV_DONE: begin
			if (busy_q) begin
				opposite = dir_t'(heading_q ^ 2'd1);
				limits_q[opposite] = 1'b0;
				limits_q[heading_q] = switch_level;
				busy_q = 1'b0;
				res.stop = 1'b1;
				res.stop_dir = heading_q;
				if (state_q == ST_DARK || state_q == ST_WIND)
					homing_step(res);
			end
		end
		EV_WIND: begin
			if (state_q == ST_AUTO) begin
				state_q = ST_WIND;
				limits_q[DIR_N] = 1'b0;
				if (!busy_q)
					homing_step(res);
			end
		end
		default: begin
			if (state_q == ST_SLEEP) begin
				if (sleep_q != '0)
					sleep_q = sleep_q - 1'b1;
				if (sleep_q == '0) begin
					state_q = ST_AUTO;
					limits_q = '0;
				end
			end
		end
		endcase
		res.state = state_q;
		res.limits = limits_q;
	endtask

	// Configuration writes, event transfers and result transfers, in that order
	always @(posedge clk) begin
		tracker_result_t want;
		if (!arst_n) begin
			band_q = RST_DEAD_BAND;
			track_time_q = RST_TRACK_TIME;
			home_time_q = RST_HOME_TIME;
			dark_ticks_q = RST_DARK_TICKS;
			wind_ticks_q = RST_WIND_TICKS;
			limits_q = '0;
			state_q = ST_AUTO;
			busy_q = 1'b0;
			heading_q = DIR_N;
			sleep_q = '0;
			awaited_results.delete();
		end else begin
			if (cfg_we) begin
				case (cfg_index)
				REG_DEAD_BAND:  band_q = cfg_data[BAND_W-1:0];
				REG_TRACK_TIME: track_time_q = cfg_data[TIME_W-1:0];
				REG_HOME_TIME:  home_time_q = cfg_data[TIME_W-1:0];
				REG_DARK_TICKS: dark_ticks_q = cfg_data[TICKS_W-1:0];
				REG_WIND_TICKS: wind_ticks_q = cfg_data[TICKS_W-1:0];
				default: ;
				endcase
			end
			if (in_valid && in_ready) begin
				decide_event(event_t'(mode), north_level, south_level, east_level,
					west_level, is_dark, limit_level, want);
				awaited_results.push_back(want);
			end
			if (out_valid && out_ready) begin
				if (awaited_results.size() == 0) begin
					report_fault("result transfer with no result awaited");
				end else begin
					want = awaited_results.pop_front();
					check_field("start_move", 32'(start_move), 32'(want.start));
					check_field("move_dir", 32'(move_dir), 32'(want.start_dir));
					check_field("move_time", 32'(move_time), 32'(want.start_time));
					check_field("stop_move", 32'(stop_move), 32'(want.stop));
					check_field("stop_dir", 32'(stop_dir), 32'(want.stop_dir));
					check_field("tracker_state", 32'(tracker_state), 32'(want.state));
					check_field("limit_flags", 32'(limit_flags), 32'(want.limits));
				end
			end
		end
		fail_count <= faults;
		awaited_count <= awaited_results.size();
	end

endmodule

// File: tb/tb_light_tracker_axis_controller.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_light_tracker_axis_controller: testbench of the light tracker controller
// Drives a directed run through tracking, dark and wind homing and the sleep
// countdown, then random events over several register settings, with random
// gaps on both channels. Checking is done by ltac_checker beside the block.
// ----------------------------------------------------------------------------
module tb_light_tracker_axis_controller;
	import ltac_pkg::*;

	localparam int MAX_GAP     = 12;
	localparam int IDLE_LIMIT  = 1000;
	localparam int PHASES      = 8;
	localparam int PHASE_ITEMS = 140;

	logic                    clk;
	logic                    arst_n;
	logic                    cfg_we;
	logic [IDX_W-1:0]        cfg_index;
	logic [CFG_W-1:0]        cfg_data;
	logic                    in_valid;
	logic                    in_ready;
	logic [1:0]              mode;
	logic [SAMPLE_BITS-1:0]  north_level;
	logic [SAMPLE_BITS-1:0]  south_level;
	logic [SAMPLE_BITS-1:0]  east_level;
	logic [SAMPLE_BITS-1:0]  west_level;
	logic                    is_dark;
	logic                    limit_level;
	logic                    out_valid;
	logic                    out_ready;
	logic                    start_move;
	logic [1:0]              move_dir;
	logic [TIME_W-1:0]       move_time;
	logic                    stop_move;
	logic [1:0]              stop_dir;
	logic [1:0]              tracker_state;
	logic [3:0]              limit_flags;
	int                      fail_count;
	int                      awaited_count;

	int                      stalled_cycles = 0;
	bit                      quiet = 1'b0;
	logic [BAND_W-1:0]       cur_band = RST_DEAD_BAND;

	light_tracker_axis_controller i_dut (.*);
	ltac_checker i_checker (.*);

	// Clock
	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// Watchdog: ends the run when no transfer happens for too long
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready)) begin
			stalled_cycles <= 0;
		end else if (stalled_cycles == IDLE_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end else begin
			stalled_cycles <= stalled_cycles + 1;
		end
	end

	// Wait in cycles before the next transfer on either side
	function automatic int draw_gap();
		return quiet ? 0 : $urandom_range(0, MAX_GAP);
	endfunction

	// Result side: random stalls before each result transfer
	initial begin
		int stall;
		out_ready <= 1'b0;
		@(posedge clk);
		forever begin
			stall = draw_gap();
			if (stall > 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (!out_valid);
		end
	end

	// Presents one event and waits for its transfer.
	task automatic send_event(input event_t ev,
		input logic [SAMPLE_BITS-1:0] north, south, east, west,
		input logic dark, input logic switch_level);
		int gap;
		gap = draw_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		mode <= ev;
		north_level <= north;
		south_level <= south;
		east_level <= east;
		west_level <= west;
		is_dark <= dark;
		limit_level <= switch_level;
		do @(posedge clk); while (!in_ready);
	endtask

	// Events other than samples, with their unused fields filled at random
	task automatic send_plain(input event_t ev, input logic switch_level);
		send_event(ev, SAMPLE_BITS'($urandom), SAMPLE_BITS'($urandom),
			SAMPLE_BITS'($urandom), SAMPLE_BITS'($urandom),
			1'($urandom_range(0, 1)), switch_level);
	endtask

	// Stops sending and waits until every awaited result has arrived.
	task automatic settle();
		in_valid <= 1'b0;
		do @(posedge clk); while (awaited_count != 0);
		repeat (2) @(posedge clk);
	endtask

	task automatic put_reg(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
	endtask

	// Writes all registers once the block is idle; spare indexes must be ignored.
	task automatic set_registers(input logic [CFG_W-1:0] band_w, track_w, home_w,
		dark_w, wind_w);
		settle();
		put_reg(REG_DEAD_BAND, band_w);
		put_reg(REG_TRACK_TIME, track_w);
		put_reg(REG_HOME_TIME, home_w);
		put_reg(REG_DARK_TICKS, dark_w);
		put_reg(REG_WIND_TICKS, wind_w);
		put_reg(IDX_W'(REG_WIND_TICKS + $urandom_range(1, 3)), CFG_W'($urandom));
		cfg_we <= 1'b0;
		cur_band = band_w[BAND_W-1:0];
	endtask

	// Two levels whose difference mostly lies close to the dead band.
	task automatic pick_pair(output logic [SAMPLE_BITS-1:0] hi, lo);
		int span;
		int diff;
		int base;
		span = int'(cur_band) + 2;
		if ($urandom_range(0, 3) == 0) begin
			hi = SAMPLE_BITS'($urandom);
			lo = SAMPLE_BITS'($urandom);
		end else begin
			diff = int'($urandom_range(0, 2 * span)) - span;
			if (diff > 1023)
				diff = 1023;
			if (diff < -1023)
				diff = -1023;
			if (diff >= 0) begin
				base = $urandom_range(0, 1023 - diff);
				lo = SAMPLE_BITS'(base);
				hi = SAMPLE_BITS'(base + diff);
			end else begin
				base = $urandom_range(0, 1023 + diff);
				hi = SAMPLE_BITS'(base);
				lo = SAMPLE_BITS'(base - diff);
			end
		end
	endtask

	// One random event; homing is left out where a long sleep would never end.
	task automatic random_event(input bit allow_homing);
		int                     pick;
		logic [SAMPLE_BITS-1:0] north, south, east, west;
		pick = $urandom_range(0, 99);
		if (pick < 40) begin
			pick_pair(north, south);
			pick_pair(east, west);
			send_event(EV_SAMPLE, north, south, east, west,
				allow_homing && ($urandom_range(0, 9) == 0), 1'($urandom_range(0, 1)));
		end else if (pick < 70) begin
			send_plain(EV_DONE, 1'($urandom_range(0, 1)));
		end else if (pick < 75 && allow_homing) begin
			send_plain(EV_WIND, 1'($urandom_range(0, 1)));
		end else begin
			send_plain(EV_TICK, 1'($urandom_range(0, 1)));
		end
	endtask

	// Stimulus and verdict
	initial begin
		arst_n <= 1'b0;
		cfg_we <= 1'b0;
		cfg_index <= REG_DEAD_BAND;
		cfg_data <= '0;
		in_valid <= 1'b0;
		mode <= EV_SAMPLE;
		north_level <= '0;
		south_level <= '0;
		east_level <= '0;
		west_level <= '0;
		is_dark <= 1'b0;
		limit_level <= 1'b0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Tracking at the reset values; a busy motor ignores even a dark sample
		send_event(EV_SAMPLE, 10'd1023, 10'd0, 10'd512, 10'd512, 1'b0, 1'b0);
		send_event(EV_SAMPLE, 10'd0, 10'd1023, 10'd0, 10'd0, 1'b1, 1'b1);
		send_plain(EV_DONE, 1'b1);
		// North is blocked by its limit, so the horizontal axis decides
		send_event(EV_SAMPLE, 10'd1023, 10'd0, 10'd0, 10'd1023, 1'b0, 1'b0);
		send_plain(EV_DONE, 1'b0);
		// Differences exactly on the dead band do not move
		send_event(EV_SAMPLE, 10'd522, 10'd512, 10'd502, 10'd512, 1'b0, 1'b1);
		send_event(EV_SAMPLE, 10'd0, 10'd1023, 10'd1023, 10'd0, 1'b0, 1'b0);
		send_plain(EV_DONE, 1'b1);
		// Motor done with the motor idle, and a tick while awake
		send_plain(EV_DONE, 1'b1);
		send_plain(EV_TICK, 1'b0);

		// Dark homing north then east, a short sleep, then wind homing
		set_registers(24'd0, 24'd0, 24'hFFFF, 24'd2, 24'd0);
		send_event(EV_SAMPLE, 10'd512, 10'd512, 10'd512, 10'd512, 1'b1, 1'b0);
		send_event(EV_SAMPLE, 10'd1023, 10'd0, 10'd0, 10'd0, 1'b0, 1'b0);
		send_plain(EV_WIND, 1'b0);
		send_plain(EV_DONE, 1'b0);
		send_plain(EV_DONE, 1'b1);
		send_plain(EV_DONE, 1'b1);
		send_event(EV_SAMPLE, 10'd0, 10'd1023, 10'd0, 10'd0, 1'b1, 1'b0);
		send_plain(EV_TICK, 1'b1);
		send_plain(EV_TICK, 1'b0);
		send_event(EV_SAMPLE, 10'd1, 10'd0, 10'd0, 10'd0, 1'b0, 1'b0);
		// Wind alarm while the motor runs waits for the motor done
		send_plain(EV_WIND, 1'b0);
		send_plain(EV_DONE, 1'b1);
		// A zero sleep time resumes on the first tick
		send_plain(EV_TICK, 1'b0);
		send_plain(EV_WIND, 1'b1);
		send_plain(EV_DONE, 1'b0);
		send_plain(EV_DONE, 1'b1);
		send_plain(EV_TICK, 1'b1);

		// Random phases; the first starts in auto mode and must not home
		for (int p = 0; p < PHASES; p++) begin
			case (p)
			0: set_registers({14'($urandom), 10'h3FF}, {8'($urandom), 16'hFFFF},
				{8'($urandom), 16'hFFFF}, 24'hFFFFFF, 24'hFFFFFF);
			1: set_registers(24'd0, 24'd0, 24'd0, 24'd0, 24'd0);
			default: set_registers(
				{14'($urandom), ($urandom_range(0, 3) == 0) ? 10'($urandom) :
					10'($urandom_range(0, 40))},
				CFG_W'($urandom), CFG_W'($urandom), CFG_W'($urandom_range(0, 6)),
				CFG_W'($urandom_range(0, 6)));
			endcase
			for (int k = 0; k < PHASE_ITEMS; k++) begin
				if (k % 40 == 0)
					quiet = ($urandom_range(0, 3) == 0);
				random_event(p != 0);
			end
		end

		settle();
		if (fail_count == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
